// ===== hw/rtl/cevq_pkg.sv =====
// Package with the shared types and constants of the coalescing event queue.
`default_nettype none

package cevq_pkg;

  // Command codes carried by the cmd field.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Event kind codes.
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_MOVE   = 2'd2;
  localparam logic [1:0] KIND_WHEEL  = 2'd3;

  // Check limits for the event values.
  localparam logic signed [15:0] KEY_MIN = 16'sd0;
  localparam logic signed [15:0] KEY_MAX = 16'sd255;
  localparam logic signed [15:0] BTN_MIN = 16'sd1;
  localparam logic signed [15:0] BTN_MAX = 16'sd5;
  localparam logic signed [15:0] VAL_NEG = 16'sh8000;
  localparam logic signed [16:0] SUM_MAX = 17'sd32767;
  localparam logic signed [16:0] SUM_MIN = -17'sd32767;

  // One held event.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] a;
    logic signed [15:0] b;
  } entry_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cevq_in_if.sv =====
// Input channel: one queue command word per handshake.
`default_nettype none

interface cevq_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [1:0]         event_kind;
  logic signed [15:0] value_a;
  logic signed [15:0] value_b;

  modport source (output valid, cmd, event_kind, value_a, value_b, input ready);
  modport sink   (input valid, cmd, event_kind, value_a, value_b, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cevq_out_if.sv =====
// Result channel: one status and pop word per handshake.
`default_nettype none

interface cevq_out_if #(
  parameter int CNT_W = 7
);
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               healthy;
  logic               out_valid;
  logic [1:0]         out_kind;
  logic signed [15:0] out_a;
  logic signed [15:0] out_b;
  logic [CNT_W-1:0]   fill_level;
  logic [CNT_W-1:0]   high_water;

  modport source (output valid, accepted, healthy, out_valid, out_kind, out_a, out_b,
                  fill_level, high_water, input ready);
  modport sink   (input valid, accepted, healthy, out_valid, out_kind, out_a, out_b,
                  fill_level, high_water, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/coalescing_event_queue_top.sv =====
// Coalescing event queue: a ring of entries in one synchronous memory, with move merging.
// A word is taken in S_IDLE and its entry is read; S_EXEC ends once the output register
// is free, and the result is registered there. A new word is taken only back in S_IDLE.
// A result waits in the output register while the next word is already taken.
// Reset (rst_n low, synchronous) empties the queue, sets health and clears stop and peak.
// The entry memory itself is not cleared; data read from an unwritten entry is never used.
`default_nettype none

module coalescing_event_queue_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  cevq_in_if.sink         in_evt,
  cevq_out_if.source      out_res
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cevq_pkg::state_t state_r, state_nxt;

  logic             stop_r;
  logic             health_r, health_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;

  // Captured command word.
  logic               ex_cmd_r;
  logic [1:0]         ex_kind_r;
  logic signed [15:0] ex_a_r;
  logic signed [15:0] ex_b_r;

  // Entry memory with registered read.
  cevq_pkg::entry_t entry_mem [QUEUE_DEPTH];
  cevq_pkg::entry_t rd_data_r;
  cevq_pkg::entry_t wr_data;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] wr_addr;
  logic             wr_en;

  // Output register.
  logic               o_valid_r;
  logic               o_accepted_r;
  logic               o_healthy_r;
  logic               o_pop_r;
  logic [1:0]         o_kind_r;
  logic signed [15:0] o_a_r;
  logic signed [15:0] o_b_r;

  logic             in_acc;
  logic             finish;
  logic [PTR_W-1:0] tail_prev;
  logic             active;
  logic             is_push;
  logic             is_pop;
  logic             check_ok;
  logic             full;
  logic signed [16:0] sum_x;
  logic signed [16:0] sum_y;
  logic             merge;
  logic             append;
  logic             pop_ok;
  logic signed [15:0] b_store;
  logic             res_accepted;

  assign in_evt.ready = (state_r == cevq_pkg::S_IDLE);
  assign in_acc       = in_evt.valid && in_evt.ready;
  assign finish       = (state_r == cevq_pkg::S_EXEC) && (!o_valid_r || out_res.ready);

  // Slot of the newest held entry.
  assign tail_prev = (tail_r == '0) ? PTR_W'(QUEUE_DEPTH - 1) : tail_r - 1'b1;

  // Pops read the head entry, pushes read the newest entry for a possible merge.
  assign rd_addr = (in_evt.cmd == cevq_pkg::CMD_POP) ? head_r : tail_prev;

  // Event check.
  always_comb begin
    case (ex_kind_r)
      cevq_pkg::KIND_KEY:    check_ok = (ex_a_r >= cevq_pkg::KEY_MIN) &&
                                        (ex_a_r <= cevq_pkg::KEY_MAX);
      cevq_pkg::KIND_BUTTON: check_ok = (ex_a_r >= cevq_pkg::BTN_MIN) &&
                                        (ex_a_r <= cevq_pkg::BTN_MAX);
      default:               check_ok = (ex_a_r != cevq_pkg::VAL_NEG) &&
                                        (ex_b_r != cevq_pkg::VAL_NEG);
    endcase
  end

  // Merge sums against the newest entry.
  assign sum_x = 17'(rd_data_r.a) + 17'(ex_a_r);
  assign sum_y = 17'(rd_data_r.b) + 17'(ex_b_r);

  assign active  = !stop_r && health_r;
  assign is_push = active && (ex_cmd_r == cevq_pkg::CMD_PUSH);
  assign is_pop  = active && (ex_cmd_r == cevq_pkg::CMD_POP);
  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign merge   = is_push && check_ok && (ex_kind_r == cevq_pkg::KIND_MOVE) &&
                   (count_r != '0) && (rd_data_r.kind == cevq_pkg::KIND_MOVE) &&
                   (sum_x >= cevq_pkg::SUM_MIN) && (sum_x <= cevq_pkg::SUM_MAX) &&
                   (sum_y >= cevq_pkg::SUM_MIN) && (sum_y <= cevq_pkg::SUM_MAX);
  assign append  = is_push && check_ok && !merge && !full;
  assign pop_ok  = is_pop && (count_r != '0);
  assign b_store = ((ex_kind_r == cevq_pkg::KIND_KEY) ||
                    (ex_kind_r == cevq_pkg::KIND_BUTTON)) ? 16'sd0 : ex_b_r;
  assign res_accepted = merge || append || pop_ok;

  // Write port: merged sums go back to the newest entry, appends go to the tail.
  always_comb begin
    wr_en   = finish && (merge || append);
    wr_addr = merge ? tail_prev : tail_r;
    if (merge) begin
      wr_data = '{kind: cevq_pkg::KIND_MOVE, a: sum_x[15:0], b: sum_y[15:0]};
    end else begin
      wr_data = '{kind: ex_kind_r, a: ex_a_r, b: b_store};
    end
  end

  // Queue bookkeeping for the step being finished.
  always_comb begin
    health_nxt = health_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    peak_nxt   = peak_r;
    if (is_push && (!check_ok || (!merge && full))) begin
      health_nxt = 1'b0;
    end
    if (append) begin
      tail_nxt  = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (pop_ok) begin
      head_nxt  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (count_nxt > peak_r) begin
      peak_nxt = count_nxt;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cevq_pkg::S_IDLE: if (in_acc) state_nxt = cevq_pkg::S_EXEC;
      cevq_pkg::S_EXEC: if (finish) state_nxt = cevq_pkg::S_IDLE;
      default:          state_nxt = cevq_pkg::S_IDLE;
    endcase
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (in_acc) begin
      rd_data_r <= entry_mem[rd_addr];
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ex_cmd_r  <= in_evt.cmd;
      ex_kind_r <= in_evt.event_kind;
      ex_a_r    <= in_evt.value_a;
      ex_b_r    <= in_evt.value_b;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cevq_pkg::S_IDLE;
      stop_r   <= 1'b0;
      health_r <= 1'b1;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      peak_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        stop_r <= cfg_wdata;
      end
      if (finish) begin
        health_r <= health_nxt;
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        count_r  <= count_nxt;
        peak_r   <= peak_nxt;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (finish) begin
      o_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  // Output payload; pop fields read zero when nothing was popped.
  always_ff @(posedge clk) begin
    if (finish) begin
      o_accepted_r <= res_accepted;
      o_healthy_r  <= health_nxt;
      o_pop_r      <= pop_ok;
      o_kind_r     <= pop_ok ? rd_data_r.kind : 2'd0;
      o_a_r        <= pop_ok ? rd_data_r.a : 16'sd0;
      o_b_r        <= pop_ok ? rd_data_r.b : 16'sd0;
    end
  end

  assign out_res.valid      = o_valid_r;
  assign out_res.accepted   = o_accepted_r;
  assign out_res.healthy    = o_healthy_r;
  assign out_res.out_valid  = o_pop_r;
  assign out_res.out_kind   = o_kind_r;
  assign out_res.out_a      = o_a_r;
  assign out_res.out_b      = o_b_r;
  assign out_res.fill_level = count_r;
  assign out_res.high_water = peak_r;

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  // The high-water mark is never below the fill count.
  a_peak_ge_count: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= count_r)
    else $error("high-water mark below fill count");

  // Health, once lost, stays lost until reset.
  a_health_latched: assert property (@(posedge clk) disable iff (!rst_n)
    !health_r |=> !health_r)
    else $error("health flag recovered without reset");

  // A popped entry is always reported as accepted.
  a_pop_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    finish && pop_ok |=> o_valid_r && o_accepted_r && o_pop_r)
    else $error("pop result not flagged as accepted");

endmodule

`default_nettype wire
